### rtl/gda_pkg.sv
package gda_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int DAYS_W  = 16;
    // exact year: up to 16383 plus the years crossed by stepping
    localparam int YACC_W  = 15;
    // year reduced modulo 400, wide enough to hold a start year
    localparam int RED_W   = 14;
    // start year over 400 is at most 40
    localparam int QUO_W   = 6;

    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;

    localparam logic [RED_W-1:0] CYCLE_400 = 14'd400;
    localparam logic [RED_W-1:0] CYCLE_END = 14'd399;

    // 1/25 scaled by 1024, floor exact for (year >> 4) up to 1023
    localparam logic [5:0] RECIP_25 = 6'd41;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_STEP,
        ST_OUT
    } gda_state_t;

    typedef struct packed {
        logic load;
        logic reduce;
        logic check;
        logic step;
    } gda_cmd_t;

    typedef struct packed {
        logic ge400;
        logic invalid;
        logic rem_zero;
        logic finish;
    } gda_sts_t;

    // days in month, zero for a month code outside 1..12
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        len = '0;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            MONTH_FEB:                                   len = leap ? 5'd29 : 5'd28;
            default:                                     len = '0;
        endcase
        return len;
    endfunction

endpackage

### rtl/gregorian_date_add_days_core.sv
// channel  | ports                      | beat contents
// ---------+----------------------------+-------------------------------------------
// input    | s_tvalid s_tready s_tdata  | start_day, start_month, start_year, days
// result   | m_tvalid m_tready m_tdata  | new_day, new_month, new_year
//          | m_tuser                    | bad_date
//
// one beat in flight at a time: accept, reduce year mod 400 by a reciprocal multiply
// (the subtract is skipped below 400), check, then one month per cycle in the stepping loop
// aresetn is synchronous and active low; s_tready is low for one cycle after it
// the result is held in the datapath registers while m_tready is low

module gregorian_date_add_days_core
    import gda_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // start_day, start_month, start_year, days_to_add, pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // new_day, new_month, new_year, pad
    output logic [0:0]  m_tuser    // bad_date
);

    // only the low bits of the day count take part
    localparam int CW = (COUNT_BITS < DAYS_W) ? COUNT_BITS : DAYS_W;

    gda_cmd_t cmd;
    gda_sts_t sts;

    logic [DAY_W-1:0]   new_day;
    logic [MONTH_W-1:0] new_month;
    logic [YEAR_W-1:0]  new_year;
    logic               bad_date;
    logic [DAYS_W-1:0]  days_to_add;

    assign days_to_add = s_tdata[38:23];

    gda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    gda_dp #(
        .CW (CW)
    ) u_dp (
        .aclk      (aclk),
        .cmd       (cmd),
        .sts       (sts),
        .in_day    (s_tdata[4:0]),
        .in_month  (s_tdata[8:5]),
        .in_year   (s_tdata[22:9]),
        .in_count  (days_to_add[CW-1:0]),
        .out_day   (new_day),
        .out_month (new_month),
        .out_year  (new_year),
        .out_bad   (bad_date)
    );

    // pack the result beat, lowest field first
    assign m_tdata = {1'b0, new_year, new_month, new_day};
    assign m_tuser = bad_date;

endmodule

### rtl/gda_ctrl.sv
module gda_ctrl
    import gda_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output gda_cmd_t cmd,
    input  gda_sts_t sts
);

    gda_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (sts.ge400) begin
                    cmd.reduce = 1'b1;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
                if (sts.invalid || sts.rem_zero) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                cmd.step = 1'b1;
                if (sts.finish) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

### rtl/gda_dp.sv
module gda_dp
    import gda_pkg::*;
#(
    parameter int CW = 16
) (
    input  logic               aclk,
    input  gda_cmd_t           cmd,
    output gda_sts_t           sts,
    input  logic [DAY_W-1:0]   in_day,
    input  logic [MONTH_W-1:0] in_month,
    input  logic [YEAR_W-1:0]  in_year,
    input  logic [CW-1:0]      in_count,
    output logic [DAY_W-1:0]   out_day,
    output logic [MONTH_W-1:0] out_month,
    output logic [YEAR_W-1:0]  out_year,
    output logic               out_bad
);

    localparam int CMPW = (CW > DAY_W) ? CW : DAY_W;

    logic [DAY_W-1:0]   day_reg;
    logic [MONTH_W-1:0] mon_reg;
    logic [YACC_W-1:0]  year_reg;
    logic [CW-1:0]      rem_reg;
    logic [RED_W-1:0]   red_reg;
    logic [QUO_W-1:0]   q_reg;
    logic               bad_reg;

    logic               leap;
    logic [DAY_W-1:0]   len;
    logic [DAY_W-1:0]   room;
    logic [15:0]        q_prod;

    // year / 400 as (year >> 4) / 25 by reciprocal multiply
    assign q_prod = {6'd0, in_year[YEAR_W-1:4]} * {10'd0, RECIP_25};

    // year mod 4 equals red mod 4 because 400 is a multiple of 4
    assign leap = ((red_reg[1:0] == 2'd0) && (red_reg != 14'd0) && (red_reg != 14'd100)
                   && (red_reg != 14'd200) && (red_reg != 14'd300))
                  || (red_reg == 14'd0);
    assign len  = month_len(mon_reg, leap);
    assign room = len - day_reg;

    always_comb begin
        sts.ge400    = (red_reg >= CYCLE_400);
        sts.invalid  = (mon_reg == '0) || (mon_reg > MONTH_DEC) || (year_reg == '0)
                       || (day_reg == '0) || (day_reg > len);
        sts.rem_zero = (rem_reg == '0);
        sts.finish   = (CMPW'(rem_reg) <= CMPW'(room));
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            day_reg  <= in_day;
            mon_reg  <= in_month;
            year_reg <= YACC_W'(in_year);
            rem_reg  <= in_count;
            red_reg  <= in_year;
            q_reg    <= q_prod[15:10];
        end
        if (cmd.reduce) begin
            red_reg <= red_reg - ({8'd0, q_reg} * CYCLE_400);
        end
        if (cmd.check) begin
            bad_reg <= sts.invalid;
        end
        if (cmd.step) begin
            if (sts.finish) begin
                day_reg <= day_reg + DAY_W'(rem_reg);
                rem_reg <= '0;
            end else begin
                rem_reg <= rem_reg - CW'(room);
                day_reg <= '0;
                if (mon_reg == MONTH_DEC) begin
                    mon_reg  <= MONTH_JAN;
                    year_reg <= year_reg + YACC_W'(1);
                    red_reg  <= (red_reg == CYCLE_END) ? '0 : red_reg + RED_W'(1);
                end else begin
                    mon_reg <= mon_reg + MONTH_W'(1);
                end
            end
        end
    end

    assign out_day   = day_reg;
    assign out_month = mon_reg;
    assign out_year  = year_reg[YEAR_W-1:0];
    assign out_bad   = bad_reg;

endmodule

### rtl/gda_chk.sv
module gda_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat dropped or changed while stalled");

    // one item at a time: no new input once a beat is taken
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("input taken while busy or result without work");

    // never ready for input while a result waits
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");

    // after the result is taken the block returns to accepting input
    a_return: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> s_tready && !m_tvalid)
        else $error("no return to idle after result beat");

endmodule

bind gregorian_date_add_days_core gda_chk u_gda_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
